// ===== rtl/button_debounce_long_press_defines.svh =====
// assertion macros used by bdlp_core
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define BDLP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bdlp_pkg.sv =====
`default_nettype none

package bdlp_pkg;

   // event codes carried by the mode field
   typedef enum logic [1:0] {
      MODE_EDGE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   localparam int MODE_W     = 2;
   localparam int BUTTON_W   = 3;
   localparam int PRESSED_W  = 7;
   localparam int FLAGS_W    = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 1'd1;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET = 16'd16;
   localparam logic [CSR_DATA_W-1:0] HOLD_RESET     = 16'd49050;

   localparam logic [FLAGS_W-1:0] LONG_PRESS_BIT = 8'h80;

   localparam int TIMER_WIDTH_DEF = 16;

   // one input item as held in the input register
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [BUTTON_W-1:0] button;
   } item_type;

   // button index to its bit in the pressed set
   function automatic logic [PRESSED_W-1:0] button_bit(input logic [BUTTON_W-1:0] idx);
      logic [PRESSED_W-1:0] bit_v;
      unique case (idx)
         3'd0:    bit_v = 7'h01;
         3'd1:    bit_v = 7'h02;
         3'd2:    bit_v = 7'h04;
         3'd3:    bit_v = 7'h10;
         3'd4:    bit_v = 7'h20;
         3'd5:    bit_v = 7'h40;
         default: bit_v = 7'h00;
      endcase
      return bit_v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bdlp_in_reg.sv =====
`default_nettype none

module bdlp_in_reg
   import bdlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [BUTTON_W-1:0] req_button,
   output      logic                req_stall,
   input  wire logic                advance,
   output      logic                s1_valid,
   output      item_type            s1_item
);

   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic     accept;

   // register is free when empty or when its item moves on this cycle
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.mode   <= req_mode;
         s1_item_ff.button <= req_button;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

`default_nettype wire

// ===== rtl/bdlp_core.sv =====
`default_nettype none

`include "button_debounce_long_press_defines.svh"

module bdlp_core
   import bdlp_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  s1_valid,
   input  wire item_type              s1_item,
   output      logic                  advance,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [FLAGS_W-1:0]    rsp_flags_out,
   output      logic                  rsp_wake
);

   localparam int CMP_W = (TIMER_WIDTH > CSR_DATA_W) ? TIMER_WIDTH : CSR_DATA_W;

   logic [CSR_DATA_W-1:0]  debounce_ff, hold_ff;
   logic [PRESSED_W-1:0]   pressed_ff, pressed_in;
   logic [FLAGS_W-1:0]     latched_ff, latched_in;
   logic [PRESSED_W-1:0]   held_ff, held_in;
   logic [FLAGS_W-1:0]     sticky_ff, sticky_in;
   logic [TIMER_WIDTH-1:0] count_ff, count_in, count_inc;
   logic                   counting_ff, counting_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FLAGS_W-1:0]     flags_ff, flags_in;
   logic                   wake_ff, wake_in;

   logic                   step_fire;
   logic                   latch_hit, hold_hit;
   logic [FLAGS_W-1:0]     latched_mid, sticky_mid;
   logic [PRESSED_W-1:0]   held_mid;

   // result register empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_fire = s1_valid && advance;

   assign count_inc = count_ff + TIMER_WIDTH'(1);
   assign latch_hit = CMP_W'(count_inc) == CMP_W'(debounce_ff);
   assign hold_hit  = CMP_W'(count_inc) == CMP_W'(hold_ff);

   always_comb begin
      pressed_in  = pressed_ff;
      latched_in  = latched_ff;
      held_in     = held_ff;
      sticky_in   = sticky_ff;
      count_in    = count_ff;
      counting_in = counting_ff;
      flags_in    = '0;
      wake_in     = 1'b0;
      latched_mid = latched_ff;
      held_mid    = held_ff;
      sticky_mid  = sticky_ff;

      unique case (s1_item.mode)
         MODE_EDGE: begin
            pressed_in  = pressed_ff ^ button_bit(s1_item.button);
            count_in    = '0;
            counting_in = 1'b1;
         end
         MODE_TICK: begin
            if (counting_ff) begin
               count_in = count_inc;
               // debounce latch first, long-press check sees its result
               if (latch_hit) begin
                  latched_mid = {1'b0, pressed_ff};
                  held_mid    = pressed_ff;
                  sticky_mid  = sticky_ff | {1'b0, pressed_ff};
                  wake_in     = 1'b1;
               end
               latched_in = latched_mid;
               held_in    = held_mid;
               sticky_in  = sticky_mid;
               if (hold_hit) begin
                  if (latched_mid == {1'b0, held_mid} && latched_mid != '0) begin
                     latched_in = latched_mid | LONG_PRESS_BIT;
                     sticky_in  = sticky_mid | latched_mid | LONG_PRESS_BIT;
                     wake_in    = 1'b1;
                  end
                  counting_in = 1'b0;
                  count_in    = '0;
               end
            end
         end
         MODE_READ: begin
            flags_in  = sticky_ff;
            sticky_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= '0;
         latched_ff   <= '0;
         held_ff      <= '0;
         sticky_ff    <= '0;
         count_ff     <= '0;
         counting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            pressed_ff  <= pressed_in;
            latched_ff  <= latched_in;
            held_ff     <= held_in;
            sticky_ff   <= sticky_in;
            count_ff    <= count_in;
            counting_ff <= counting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         flags_ff <= flags_in;
         wake_ff  <= wake_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            CSR_HOLD:     hold_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_flags_out = flags_ff;
   assign rsp_wake      = wake_ff;

   `BDLP_ASSERT_NOW(a_stopped_count_zero, !counting_ff, count_ff == '0,
      "tick counter not cleared while stopped")
   `BDLP_ASSERT_NOW(a_latched_held_match, 1'b1, latched_ff[PRESSED_W-1:0] == held_ff,
      "latched set drifted from held set")
   `BDLP_ASSERT_NEXT(a_read_clears, step_fire && s1_item.mode == MODE_READ,
      sticky_ff == '0, "sticky flags survived a read")
   `BDLP_ASSERT_NOW(a_long_press_wakes,
      latched_ff[FLAGS_W-1] && !$past(latched_ff[FLAGS_W-1]),
      rsp_valid_ff && wake_ff, "long press set without wake")

endmodule

`default_nettype wire

// ===== rtl/button_debounce_long_press.sv =====
// channel  | ports                          | transfer when
// ---------+--------------------------------+---------------------------
// request  | req_mode, req_button           | req_valid && !req_stall
// response | rsp_flags_out, rsp_wake        | rsp_valid && !rsp_stall
// csr      | csr_index, csr_data            | csr_valid && csr_ready
//
// one request per cycle sustained while no response is held; a response follows its
// request transfer through the input register, then the state update stage
// the single state update stage sets the rate: each request reads and
// writes the button state once
// reset is synchronous, active high: state cleared, timer stopped, thresholds
// back to 16 and 49050 ticks
// a held response stalls the update stage; req_stall rises once the input
// register is also full
`default_nettype none

module button_debounce_long_press
   import bdlp_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [BUTTON_W-1:0]   req_button,
   // response channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [FLAGS_W-1:0]    rsp_flags_out,
   output      logic                  rsp_wake,
   // register write port
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic     advance;
   logic     s1_valid;
   item_type s1_item;

   // register writes land in the next cycle, always taken
   assign csr_ready = 1'b1;

   // input register, decouples the request side from the update stage
   bdlp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_mode   (req_mode),
      .req_button (req_button),
      .req_stall  (req_stall),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item)
   );

   // button state, tick counter, thresholds and response register
   bdlp_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid),
      .s1_item       (s1_item),
      .advance       (advance),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_flags_out (rsp_flags_out),
      .rsp_wake      (rsp_wake)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bdlp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int ITEM_BUDGET  = 1850;
   localparam int PHASE_ITEMS  = 300;
   localparam int MAX_REPORTS  = 10;

   // one expected response
   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic               wake;
   } rsp_expect_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode;
   logic [BUTTON_W-1:0]   req_button;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [FLAGS_W-1:0]    rsp_flags_out;
   logic                  rsp_wake;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // debouncer model state, reset values as after a block reset
   logic [PRESSED_W-1:0]  pressed_set = '0;
   logic [FLAGS_W-1:0]    latched_set = '0;
   logic [FLAGS_W-1:0]    held_set = '0;
   logic [FLAGS_W-1:0]    sticky_set = '0;
   logic [15:0]           tick_cnt = '0;
   logic                  timer_on = 1'b0;
   logic [CSR_DATA_W-1:0] debounce_limit = DEBOUNCE_RESET;
   logic [CSR_DATA_W-1:0] hold_limit = HOLD_RESET;

   rsp_expect_type expected_rsp[$];
   int          error_count = 0;
   int          rsp_count = 0;
   int          counted_items = 0;
   // per-item idle draws, 0 turns idling off for that side
   int          gap_max = 0;
   int          stall_max = 0;

   button_debounce_long_press dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_button    (req_button),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_flags_out (rsp_flags_out),
      .rsp_wake      (rsp_wake),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // bit of the pressed set for a button index; 3 is skipped, 6 and 7 hit nothing
   function automatic logic [PRESSED_W-1:0] button_mask(input logic [BUTTON_W-1:0] b);
      if (b < 3) begin
         return PRESSED_W'(1 << b);
      end else if (b < 6) begin
         return PRESSED_W'(1 << (b + 1));
      end
      return '0;
   endfunction

   // advance the debouncer model by one request, return what the block should answer
   function automatic rsp_expect_type debounce_predict(input logic [MODE_W-1:0] mode,
                                                       input logic [BUTTON_W-1:0] button);
      rsp_expect_type r;
      r = '0;
      case (mode)
         MODE_EDGE: begin
            // toggle and restart the count, even for unknown buttons
            pressed_set = pressed_set ^ button_mask(button);
            tick_cnt = '0;
            timer_on = 1'b1;
         end
         MODE_TICK: begin
            if (timer_on) begin
               // wraps in 16 bits, compared after the increment
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt == debounce_limit) begin
                  latched_set = {1'b0, pressed_set};
                  sticky_set = sticky_set | latched_set;
                  held_set = latched_set;
                  r.wake = 1'b1;
               end
               // long-press check comes after the latch on the same tick
               if (tick_cnt == hold_limit) begin
                  if (latched_set == held_set && latched_set != '0) begin
                     latched_set = latched_set | LONG_PRESS_BIT;
                     sticky_set = sticky_set | latched_set;
                     r.wake = 1'b1;
                  end
                  timer_on = 1'b0;
                  tick_cnt = '0;
               end
            end
         end
         MODE_READ: begin
            r.flags = sticky_set;
            sticky_set = '0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // one request transfer; entered and left just after a falling edge
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BUTTON_W-1:0] button);
      int gap;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_button <= button;
      do @(posedge clock); while (req_stall);
      counted_items++;
      expected_rsp.push_back(debounce_predict(mode, button));
      @(negedge clock);
   endtask

   // stop sending and wait until every expected response has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      // pipeline is two stages deep, give it a little more
      repeat (4) @(negedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DEBOUNCE) begin
         debounce_limit = value;
      end else begin
         hold_limit = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // reset thresholds: latch at 16 ticks, the hold count stays out of reach
   task automatic test_reset_thresholds();
      gap_max = 0;
      stall_max = 0;
      send_item(MODE_READ, 3'd0);
      // tick while the counter is stopped
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_EDGE, 3'd0);
      send_item(MODE_EDGE, 3'd5);
      repeat (int'(DEBOUNCE_RESET) + 4) send_item(MODE_TICK, 3'd0);
      send_item(MODE_READ, 3'd7);
   endtask

   task automatic test_directed();
      int b;
      drain();
      write_csr(CSR_DEBOUNCE, 16'd1);
      write_csr(CSR_HOLD, 16'd3);
      gap_max = 12;
      stall_max = 12;
      // every button index, unknown ones only restart the count
      for (b = 0; b < 8; b++) send_item(MODE_EDGE, BUTTON_W'(b));
      // latch, quiet tick, long press, then a tick while stopped
      repeat (4) send_item(MODE_TICK, 3'd7);
      send_item(MODE_UNUSED, 3'd7);
      // second read must come back clear
      repeat (2) send_item(MODE_READ, 3'd0);

      // equal thresholds: latch and long press on the same tick
      drain();
      write_csr(CSR_HOLD, 16'd2);
      write_csr(CSR_DEBOUNCE, 16'd2);
      send_item(MODE_EDGE, 3'd1);
      repeat (2) send_item(MODE_TICK, 3'd0);
      send_item(MODE_READ, 3'd0);

      // leave a plain latch behind, then restart the count
      drain();
      write_csr(CSR_DEBOUNCE, 16'd1);
      write_csr(CSR_HOLD, 16'd3);
      send_item(MODE_EDGE, 3'd4);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_EDGE, 3'd4);
      // hold below debounce: the check sees the sets of the earlier latch
      drain();
      write_csr(CSR_DEBOUNCE, 16'd2);
      write_csr(CSR_HOLD, 16'd1);
      send_item(MODE_TICK, 3'd0);
      send_item(MODE_READ, 3'd0);
   endtask

   task automatic test_random_traffic();
      int phase;
      int goal;
      int phase_end;
      int n;
      bit paused;
      logic [CSR_DATA_W-1:0] deb;
      logic [CSR_DATA_W-1:0] hld;
      goal = ITEM_BUDGET;
      phase = 0;
      paused = 1'b0;
      while (counted_items < goal) begin
         drain();
         deb = CSR_DATA_W'($urandom_range(1, 12));
         case ($urandom_range(0, 3))
            0: hld = deb;
            1: hld = (deb > 1) ? CSR_DATA_W'($urandom_range(1, deb - 1)) : deb;
            default: hld = deb + CSR_DATA_W'($urandom_range(1, 30));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_csr(CSR_DEBOUNCE, deb);
            write_csr(CSR_HOLD, hld);
         end else begin
            write_csr(CSR_HOLD, hld);
            write_csr(CSR_DEBOUNCE, deb);
         end
         // some phases run without idling on one side or the other
         gap_max   = (phase % 3 == 1) ? 0 : 12;
         stall_max = (phase % 4 == 2) ? 0 : 12;
         phase_end = counted_items + PHASE_ITEMS;
         while (counted_items < phase_end && counted_items < goal) begin
            // once, halfway into the second phase, let everything drain
            if (phase == 1 && !paused && counted_items > phase_end - PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
               // a press or release burst, then a tick run of up to three ticks past hold
               repeat ($urandom_range(1, 3)) begin
                  send_item(MODE_EDGE, ($urandom_range(0, 15) == 0) ?
                            BUTTON_W'($urandom_range(6, 7)) :
                            BUTTON_W'($urandom_range(0, 5)));
               end
               n = $urandom_range(0, hld + 3);
               repeat (n) begin
                  if ($urandom_range(0, 11) == 0) send_item(MODE_READ, BUTTON_W'($urandom));
                  send_item(MODE_TICK, BUTTON_W'($urandom));
               end
               if ($urandom_range(0, 2) == 0) send_item(MODE_READ, BUTTON_W'($urandom));
            end else begin
               // noise, unused mode and unknown buttons included
               repeat ($urandom_range(1, 6)) send_item(MODE_W'($urandom), BUTTON_W'($urandom));
            end
         end
         phase++;
      end
   endtask

   // response side: compare on each transfer, then draw a stall for the next
   initial begin : rsp_side
      int stall_left;
      rsp_expect_type want;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: response %0d with nothing expected: flags %02h wake %b",
                           $time, rsp_count, rsp_flags_out, rsp_wake);
               end
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_flags_out !== want.flags || rsp_wake !== want.wake) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: response %0d: flags exp %02h got %02h, wake exp %b got %b",
                              $time, rsp_count, want.flags, rsp_flags_out, want.wake,
                              rsp_wake);
                  end
               end
            end
            stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
         end
         @(negedge clock);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // run limit, well above the slowest legal run
   initial begin
      #6_000_000;
      $display("FAIL button_debounce_long_press");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = MODE_EDGE;
      req_button = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_DEBOUNCE;
      csr_data   = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_thresholds();
      test_directed();
      test_random_traffic();

      drain();
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("PASS button_debounce_long_press");
      end else begin
         $display("FAIL button_debounce_long_press");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/bdlp_in_reg.sv
rtl/bdlp_core.sv
rtl/button_debounce_long_press.sv
test/tb.sv
